// File: src/brb_pkg.sv
`default_nettype none

package brb_pkg;

   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CAP_W = IDX_W + 1;

   localparam int MODE_W = 3;
   localparam int DATA_W = 8;
   localparam int LEN_W = 11;
   localparam int OFF_W = 10;
   localparam int STAT_W = 2;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic [MODE_W-1:0] MODE_WRITE_BEGIN = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_BYTE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STATUS = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_REFUSED = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NO_BURST = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// File: src/byte_ring_buffer_top.sv
// rsp_tvalid follows the load, execute and result steps of the controller; the
//   result step waits for a free output register and takes the registered read
//   of the single-port byte store, and a new item is taken only after the result step
// a new item is taken while an earlier result still waits in the output register
// reset is synchronous: indices, fill level and burst clear, capacity returns to 1024;
//   the byte store is not cleared and needs no clearing pass
`default_nettype none

module byte_ring_buffer_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // data_byte[7:0], length[18:8], offset[28:19], zero fill above
   input  wire logic [brb_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // mode[2:0]
   input  wire logic [brb_pkg::MODE_W-1:0]          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status[1:0], read_byte[9:2], done_count[20:10], used_count[30:21],
   // free_count[41:31], zero fill above
   output logic      [brb_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [brb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [brb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [brb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   import brb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_pready = 1'b1;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brb_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_mode     (req_tuser),
      .req_data_byte(req_tdata[7:0]),
      .req_length   (req_tdata[18:8]),
      .req_offset   (req_tdata[28:19]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata)
   );

endmodule

`default_nettype wire

// File: src/brb_ram.sv
`default_nettype none

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: src/brb_ctrl.sv
`default_nettype none

module brb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire brb_pkg::stat_type stat,
   output brb_pkg::cmd_type       cmd
);

   import brb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.exec = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            // wait for the output register to take the result
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/brb_datapath.sv
`default_nettype none

module brb_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire brb_pkg::cmd_type                    cmd,
   output brb_pkg::stat_type                        stat,
   input  wire logic [brb_pkg::MODE_W-1:0]          req_mode,
   input  wire logic [brb_pkg::DATA_W-1:0]          req_data_byte,
   input  wire logic [brb_pkg::LEN_W-1:0]           req_length,
   input  wire logic [brb_pkg::OFF_W-1:0]           req_offset,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [brb_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [brb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [brb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [brb_pkg::CSR_DATA_W-1:0]      csr_prdata
);

   import brb_pkg::*;

   // latched item
   logic [MODE_W-1:0] mode_ff;
   logic [DATA_W-1:0] data_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [OFF_W-1:0]  off_ff;

   // buffer state
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] used_ff, used_in;
   logic [LEN_W-1:0] burst_ff, burst_in;
   logic [CAP_W-1:0] cap_raw_ff;
   logic [CAP_W-1:0] cap_eff_ff;
   logic [CAP_W-1:0] cap_clamp;

   // pending result
   logic [STAT_W-1:0] st_ff, st_in;
   logic [LEN_W-1:0]  done_ff, done_in;
   logic              peek_ok_ff, peek_ok_in;

   // output register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic             csr_write;
   logic [LEN_W+1:0] burst_need;
   logic [CAP_W-1:0] burst_limit;
   logic [IDX_W-1:0] peek_pos;
   logic [IDX_W-1:0] del_count;
   logic             ram_we;
   logic [IDX_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_q;
   logic [DATA_W-1:0] rd_byte;
   logic [CAP_W-1:0] free_count;

   function automatic logic [IDX_W-1:0] wrap_add(
      input logic [IDX_W-1:0] a,
      input logic [IDX_W-1:0] b,
      input logic [CAP_W-1:0] cap
   );
      logic [CAP_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= cap) begin
         s = s - cap;
      end
      return s[IDX_W-1:0];
   endfunction

   assign csr_write = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[2] == REG_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY)
                       ? CSR_DATA_W'(cap_raw_ff) : '0;

   always_comb begin
      cap_clamp = csr_pwdata[CAP_W-1:0];
      if (cap_clamp < CAP_W'(2)) begin
         cap_clamp = CAP_W'(2);
      end else if (cap_clamp > CAP_W'(DEPTH)) begin
         cap_clamp = CAP_W'(DEPTH);
      end
   end

   assign burst_need = (LEN_W+2)'(len_ff) + (LEN_W+2)'(used_ff);
   assign burst_limit = cap_eff_ff - CAP_W'(2);
   assign peek_pos = wrap_add(head_ff, IDX_W'(off_ff), cap_eff_ff);
   assign del_count = (len_ff < LEN_W'(used_ff)) ? IDX_W'(len_ff) : used_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      used_in = used_ff;
      burst_in = burst_ff;
      st_in = STATUS_OK;
      done_in = '0;
      peek_ok_in = 1'b0;
      ram_we = 1'b0;
      ram_addr = peek_pos;
      unique case (mode_ff)
         MODE_WRITE_BEGIN: begin
            if (burst_need <= (LEN_W+2)'(burst_limit)) begin
               burst_in = len_ff;
               done_in = len_ff;
            end else begin
               burst_in = '0;
               st_in = STATUS_REFUSED;
            end
         end
         MODE_WRITE_BYTE: begin
            ram_addr = tail_ff;
            if (burst_ff != '0) begin
               ram_we = cmd.exec;
               tail_in = wrap_add(tail_ff, IDX_W'(1), cap_eff_ff);
               used_in = used_ff + IDX_W'(1);
               burst_in = burst_ff - LEN_W'(1);
            end else begin
               st_in = STATUS_NO_BURST;
            end
         end
         MODE_PEEK: begin
            if (IDX_W'(off_ff) < used_ff) begin
               peek_ok_in = 1'b1;
            end else begin
               st_in = STATUS_REFUSED;
            end
         end
         MODE_DELETE: begin
            head_in = wrap_add(head_ff, del_count, cap_eff_ff);
            used_in = used_ff - del_count;
            done_in = LEN_W'(del_count);
         end
         default: begin
            // status and unused modes only report
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         used_ff <= '0;
         burst_ff <= '0;
         cap_raw_ff <= CAP_W'(DEPTH);
         cap_eff_ff <= CAP_W'(DEPTH);
      end else if (csr_write) begin
         head_ff <= '0;
         tail_ff <= '0;
         used_ff <= '0;
         burst_ff <= '0;
         cap_raw_ff <= csr_pwdata[CAP_W-1:0];
         cap_eff_ff <= cap_clamp;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         used_ff <= used_in;
         burst_ff <= burst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         data_ff <= req_data_byte;
         len_ff <= req_length;
         off_ff <= req_offset;
      end
      if (cmd.exec) begin
         st_ff <= st_in;
         done_ff <= done_in;
         peek_ok_ff <= peek_ok_in;
      end
   end

   // a peek address stays put during the result stage so the read data holds
   brb_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(data_ff),
      .rdata(ram_q)
   );

   assign rd_byte = peek_ok_ff ? ram_q : '0;
   assign free_count = cap_eff_ff - CAP_W'(used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= RSP_TDATA_W'({free_count, used_ff, done_ff, rd_byte, st_ff});
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_head_range : assert property (@(posedge clock) disable iff (reset)
      CAP_W'(head_ff) < cap_eff_ff)
      else $error("head index beyond capacity");

   a_tail_range : assert property (@(posedge clock) disable iff (reset)
      CAP_W'(tail_ff) < cap_eff_ff)
      else $error("tail index beyond capacity");

   a_used_match : assert property (@(posedge clock) disable iff (reset)
      (tail_ff >= head_ff) ? (used_ff == tail_ff - head_ff)
      : (CAP_W'(used_ff) == cap_eff_ff - CAP_W'(head_ff - tail_ff)))
      else $error("fill level disagrees with indices");

   a_emit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result loaded over a waiting result");

   a_write_burst : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (burst_ff != '0) && (mode_ff == MODE_WRITE_BYTE))
      else $error("store written outside a burst");

endmodule

`default_nettype wire

// File: tb/sv/byte_ring_buffer_top_tb.sv
`timescale 1ns / 1ps

module byte_ring_buffer_top_tb;
   import brb_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 190;
   localparam int NUM_PHASES = 9;
   localparam int REPORT_CAP = 30;

   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
   // modes without a name of their own behave as a status item
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST = 3'd7;

   typedef struct packed {
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic [DATA_W-1:0] data_byte;
   } req_fields_type;

   typedef struct packed {
      logic [CAP_W-1:0]  free_count;
      logic [IDX_W-1:0]  used_count;
      logic [LEN_W-1:0]  done_count;
      logic [DATA_W-1:0] read_byte;
      logic [STAT_W-1:0] status;
   } reply_type;

   typedef struct {
      logic [MODE_W-1:0] mode;
      req_fields_type    f;
      bit                typed;
      reply_type         want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [MODE_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   byte_ring_buffer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the ring
   logic [DATA_W-1:0] ring_bytes [DEPTH];
   logic [IDX_W-1:0]  ring_head;
   logic [IDX_W-1:0]  ring_tail;
   logic [LEN_W-1:0]  ring_burst;
   logic [LEN_W-1:0]  cap_reg;

   reply_type owed_replies [$];
   dir_row_type dir_rows [$];

   int fail_count = 0;
   int items_sent = 0;
   int replies_seen = 0;
   int settings_done = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asked = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   bit cur_typed = 1'b0;
   reply_type cur_want = '0;

   task automatic flag_mismatch(input string what, input logic [47:0] got,
                                input logic [47:0] want);
      if (fail_count < REPORT_CAP) begin
         $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      end
      fail_count++;
   endtask

   function automatic int eff_capacity();
      int c;
      c = int'(cap_reg);
      if (c < 2) c = 2;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic int fill_level(input int c);
      if (int'(ring_head) >= c || int'(ring_tail) >= c) return 0;
      if (ring_tail >= ring_head) return int'(ring_tail) - int'(ring_head);
      return c - (int'(ring_head) - int'(ring_tail));
   endfunction

   function automatic int wrap_index(input int a, input int b, input int c);
      int s;
      s = a + b;
      if (s >= c) s = s - c;
      if (s >= c) s = 0;
      return s;
   endfunction

   function automatic void load_capacity(input logic [LEN_W-1:0] v);
      cap_reg = v;
      ring_head = '0;
      ring_tail = '0;
      ring_burst = '0;
   endfunction

   function automatic reply_type ring_step(input logic [MODE_W-1:0] mode,
                                           input req_fields_type f);
      reply_type r;
      int c, used, len, off, n;
      r = '0;
      c = eff_capacity();
      used = fill_level(c);
      len = int'(f.length);
      off = int'(f.offset);
      case (mode)
         MODE_WRITE_BEGIN: begin
            if (len + used <= c - 2) begin
               ring_burst = f.length;
               r.done_count = f.length;
            end else begin
               ring_burst = '0;
               r.status = STATUS_REFUSED;
            end
         end
         MODE_WRITE_BYTE: begin
            if (ring_burst > 0 && int'(ring_tail) < c) begin
               ring_bytes[ring_tail] = f.data_byte;
               ring_tail = IDX_W'(wrap_index(int'(ring_tail), 1, c));
               ring_burst = ring_burst - 1'b1;
            end else begin
               r.status = STATUS_NO_BURST;
            end
         end
         MODE_PEEK: begin
            if (off < used) begin
               r.read_byte = ring_bytes[wrap_index(int'(ring_head), off, c)];
            end else begin
               r.status = STATUS_REFUSED;
            end
         end
         MODE_DELETE: begin
            n = (len < used) ? len : used;
            ring_head = IDX_W'(wrap_index(int'(ring_head), n, c));
            r.done_count = LEN_W'(n);
         end
         default: ;
      endcase
      used = fill_level(c);
      r.used_count = IDX_W'(used);
      r.free_count = CAP_W'(c - used);
      return r;
   endfunction

   // check replies first so a same-edge reply never sees its own request
   always @(posedge clock) begin : watch_bus
      reply_type got, want;
      req_fields_type f;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(reply_type)-1:0];
            if (owed_replies.size() == 0) begin
               flag_mismatch("reply with nothing owed", rsp_tdata, '0);
            end else begin
               want = owed_replies.pop_front();
               replies_seen++;
               if (got.status !== want.status)
                  flag_mismatch("status", got.status, want.status);
               if (got.read_byte !== want.read_byte)
                  flag_mismatch("read_byte", got.read_byte, want.read_byte);
               if (got.done_count !== want.done_count)
                  flag_mismatch("done_count", got.done_count, want.done_count);
               if (got.used_count !== want.used_count)
                  flag_mismatch("used_count", got.used_count, want.used_count);
               if (got.free_count !== want.free_count)
                  flag_mismatch("free_count", got.free_count, want.free_count);
            end
         end
         if (req_tvalid && req_tready) begin
            f = req_tdata[$bits(req_fields_type)-1:0];
            want = ring_step(req_tuser, f);
            owed_replies.push_back(cur_typed ? cur_want : want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver side, with an occasional long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // entered and left just after a falling edge
   task automatic send_item(input logic [MODE_W-1:0] mode, input req_fields_type f,
                            input bit typed, input reply_type want);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      cur_typed = typed;
      cur_want = want;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_TDATA_W'(f);
      req_tuser <= mode;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                          input logic [LEN_W-1:0] len, input logic [OFF_W-1:0] off);
      req_fields_type f;
      f.data_byte = data;
      f.length = len;
      f.offset = off;
      send_item(mode, f, 1'b0, '0);
   endtask

   task automatic wait_replies();
      req_tvalid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= CAP_ADDR;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (is_write) load_capacity(wdata[LEN_W-1:0]);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_capacity(input logic [LEN_W-1:0] v);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, CSR_DATA_W'(v), rd);
      csr_access(1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(v)) flag_mismatch("capacity readback", rd, v);
      settings_done++;
   endtask

   function automatic void add_row(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                                   input logic [LEN_W-1:0] len, input logic [OFF_W-1:0] off,
                                   input bit typed = 1'b0,
                                   input logic [STAT_W-1:0] st = STATUS_OK,
                                   input logic [LEN_W-1:0] done = '0,
                                   input logic [IDX_W-1:0] used = '0,
                                   input logic [CAP_W-1:0] free = '0);
      dir_row_type row;
      row.mode = mode;
      row.f.data_byte = data;
      row.f.length = len;
      row.f.offset = off;
      row.typed = typed;
      row.want = '0;
      row.want.status = st;
      row.want.done_count = done;
      row.want.used_count = used;
      row.want.free_count = free;
      dir_rows.push_back(row);
   endfunction

   task automatic run_random(input int budget);
      int n_items, c, used, room, len, pick, n;
      bit paused;
      n_items = 0;
      paused = 1'b0;
      while (n_items < budget) begin
         c = eff_capacity();
         used = fill_level(c);
         room = c - 2 - used;
         pick = $urandom_range(99);
         if (pick < 45) begin
            // burst: mostly short and fitting, now and then full or oversized
            pick = $urandom_range(99);
            if (pick < 5) len = $urandom_range(2047);
            else if (room < 0) len = $urandom_range(3);
            else if (pick < 10 && room <= 200) len = room;
            else if (pick < 30) len = $urandom_range(room < 64 ? room : 64);
            else len = $urandom_range(room < 8 ? room : 8);
            send_op(MODE_WRITE_BEGIN, DATA_W'($urandom), LEN_W'(len), OFF_W'($urandom));
            n = int'(ring_burst);
            pick = $urandom_range(9);
            if (pick == 0) n = n + 1;
            else if (pick == 1) n = n / 2;
            repeat (n) send_op(MODE_WRITE_BYTE, DATA_W'($urandom), LEN_W'($urandom),
                               OFF_W'($urandom));
            n_items += n + 1;
         end else if (pick < 65) begin
            if (used > 0 && $urandom_range(4) != 0) len = $urandom_range(used - 1);
            else len = $urandom_range(1023);
            send_op(MODE_PEEK, DATA_W'($urandom), LEN_W'($urandom), OFF_W'(len));
            n_items++;
         end else if (pick < 83) begin
            pick = $urandom_range(9);
            if (pick < 6) len = $urandom_range(used);
            else if (pick < 9) len = $urandom_range(4);
            else len = $urandom_range(2047);
            send_op(MODE_DELETE, DATA_W'($urandom), LEN_W'(len), OFF_W'($urandom));
            n_items++;
         end else if (pick < 93) begin
            send_op(MODE_W'(MODE_STATUS + $urandom_range(3)), DATA_W'($urandom),
                    LEN_W'($urandom), OFF_W'($urandom));
            n_items++;
         end else begin
            send_op(MODE_WRITE_BYTE, DATA_W'($urandom), LEN_W'($urandom), OFF_W'($urandom));
            n_items++;
         end
         if (!paused && n_items >= budget / 2) begin
            paused = 1'b1;
            wait_replies();
         end
      end
   endtask

   initial begin
      int cap_plan [NUM_PHASES];
      int gap_plan [4];
      int stall_plan [4];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      load_capacity(LEN_W'(DEPTH));

      cap_plan = '{2, 0, 1, 1025, 2047, 16, 7, $urandom_range(1023, 3), DEPTH};
      gap_plan = '{0, 59, 0, 18};
      stall_plan = '{0, 0, 59, 18};

      // fresh buffer after reset, capacity 1024
      add_row(MODE_STATUS, 8'h00, 11'd0, 10'd0, 1'b1, STATUS_OK, 11'd0, 10'd0, 11'd1024);
      add_row(MODE_WRITE_BYTE, 8'hFF, 11'd0, 10'd0, 1'b1, STATUS_NO_BURST, 11'd0, 10'd0,
              11'd1024);
      add_row(MODE_PEEK, 8'h00, 11'd0, 10'd0, 1'b1, STATUS_REFUSED, 11'd0, 10'd0, 11'd1024);
      add_row(MODE_PEEK, 8'h00, 11'd0, 10'd1023, 1'b1, STATUS_REFUSED, 11'd0, 10'd0, 11'd1024);
      add_row(MODE_DELETE, 8'h00, 11'd1024, 10'd0, 1'b1, STATUS_OK, 11'd0, 10'd0, 11'd1024);
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd1023, 10'd0, 1'b1, STATUS_REFUSED, 11'd0, 10'd0,
              11'd1024);
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd2047, 10'd0, 1'b1, STATUS_REFUSED, 11'd0, 10'd0,
              11'd1024);
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd1022, 10'd0, 1'b1, STATUS_OK, 11'd1022, 10'd0,
              11'd1024);
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd0, 10'd0, 1'b1, STATUS_OK, 11'd0, 10'd0, 11'd1024);
      add_row(MODE_WRITE_BYTE, 8'h00, 11'd0, 10'd0, 1'b1, STATUS_NO_BURST, 11'd0, 10'd0,
              11'd1024);
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd4, 10'd0, 1'b1, STATUS_OK, 11'd4, 10'd0, 11'd1024);
      add_row(MODE_WRITE_BYTE, 8'h00, 11'd0, 10'd0);
      add_row(MODE_WRITE_BYTE, 8'hFF, 11'h7FF, 10'h3FF);
      add_row(MODE_WRITE_BYTE, 8'hA5, 11'd0, 10'd0);
      add_row(MODE_WRITE_BYTE, 8'h5A, 11'd0, 10'd0);
      add_row(MODE_WRITE_BYTE, 8'h3C, 11'd0, 10'd0);
      add_row(MODE_PEEK, 8'h00, 11'd0, 10'd0);
      add_row(MODE_PEEK, 8'h00, 11'd0, 10'd3);
      add_row(MODE_PEEK, 8'h00, 11'd0, 10'd4);
      // a new burst cuts the rest of the old one short
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd3, 10'd0);
      add_row(MODE_WRITE_BYTE, 8'h81, 11'd0, 10'd0);
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd2, 10'd0);
      add_row(MODE_WRITE_BYTE, 8'h7E, 11'd0, 10'd0);
      add_row(MODE_WRITE_BYTE, 8'h18, 11'd0, 10'd0);
      add_row(MODE_WRITE_BYTE, 8'h99, 11'd0, 10'd0);
      // a refused begin drops the pending burst
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd5, 10'd0);
      add_row(MODE_WRITE_BEGIN, 8'h00, 11'd2047, 10'd0);
      add_row(MODE_WRITE_BYTE, 8'h42, 11'd0, 10'd0);
      add_row(MODE_DELETE, 8'h00, 11'd2, 10'd0);
      add_row(MODE_DELETE, 8'h00, 11'd2047, 10'd0);
      add_row(MODE_SPARE_FIRST, 8'hFF, 11'h7FF, 10'h3FF);
      add_row(MODE_SPARE_LAST, 8'h00, 11'd0, 10'd0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i].mode, dir_rows[i].f, dir_rows[i].typed,
                                      dir_rows[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_replies();
         set_capacity(LEN_W'(cap_plan[p]));
         req_gap_pct = gap_plan[p % 4];
         rsp_stall_pct = stall_plan[p % 4];
         if (p == 4 || p == NUM_PHASES - 1) begin
            // output blocked while the sender keeps pushing
            @(posedge clock);
            hold_asked++;
            @(negedge clock);
         end
         run_random(PHASE_ITEMS);
      end
      wait_replies();

      $display("sent %0d items (%0d directed) over %0d capacity settings, %0d replies checked",
               items_sent, dir_rows.size(), settings_done, replies_seen);
      $display("mismatches counted: %0d", fail_count);
      if (fail_count == 0 && owed_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: files.f
src/brb_pkg.sv
src/brb_ram.sv
src/brb_ctrl.sv
src/brb_datapath.sv
src/byte_ring_buffer_top.sv
tb/sv/byte_ring_buffer_top_tb.sv
